// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define SCB_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Checked on every edge, reset included.
`define SCB_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/scb_pkg.sv -----
// ---------------------------------------------------------------------------
// Speckle contrast blocks package
// Shared widths, register indexes and the item passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none
package scb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MAX_BLOCK  = 32;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 18;
  localparam int SQ_W   = 26;
  localparam int CNT_W  = 12;
  localparam int IDX_W  = 11;
  localparam int BS_W   = 6;
  localparam int DIM_W  = 12;
  localparam int N_W    = 11;
  localparam int RES_W  = 8;
  localparam int CFG_W  = 2;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int ST_W   = SUM_W + SQ_W;

  localparam logic [RES_W-1:0] SCALE = 8'd255;

  localparam logic [CFG_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic [SUM_W-1:0] s1;
    logic [SQ_W-1:0]  s2;
    logic [N_W-1:0]   n;
    logic [IDX_W-1:0] block_row;
    logic [IDX_W-1:0] block_col;
    logic             frame_done;
  } scb_item_t;

endpackage
`default_nettype wire

// ----- rtl/scb_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module scb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/scb_fifo.sv -----
// ---------------------------------------------------------------------------
// Block result queue
// Two-entry queue of finished block sums between front and back.
// ---------------------------------------------------------------------------
`default_nettype none
module scb_fifo
  import scb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  scb_item_t      push_item,
  output logic           full,
  input  wire logic      pop,
  output scb_item_t      pop_item,
  output logic           empty
);

  scb_item_t   mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/scb_front.sv -----
// ---------------------------------------------------------------------------
// Speckle contrast front end
// Tracks the raster position, accumulates per block column sums in RAM and
// queues each finished block.
// ---------------------------------------------------------------------------
`default_nettype none
module scb_front
  import scb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  input  wire logic [CFG_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] in_pixel,
  input  wire logic             in_sof,
  output logic                  push,
  output scb_item_t             push_item,
  input  wire logic             full
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [BS_W-1:0]  bs_r;
  logic [DIM_W-1:0] w_r, h_r;
  logic [CNT_W-1:0] cc_r, rc_r, bci_r, bri_r;
  logic [BS_W-1:0]  cib_r, rib_r;

  logic [BS_W-1:0]  bs_e;
  logic [DIM_W-1:0] w_e, h_e;
  logic [CNT_W-1:0] cc0, rc0, bci0, bri0;
  logic [BS_W-1:0]  cib0, rib0;
  logic [CNT_W-1:0] cc1, rc1, bci1, bri1;
  logic [BS_W-1:0]  cib1, rib1;
  logic [18:0]      colp, rowp;
  logic             active, in_blk, first, emit, last_col, last_row, accept;

  // Latched per pixel for the read-modify-write cycle.
  logic [PIX_W-1:0]  pix_r;
  logic              first_r, emit_r;
  logic [ADDR_W-1:0] addr_r;
  logic [N_W-1:0]    n_r;
  logic [IDX_W-1:0]  orow_r, ocol_r;
  logic              fdone_r;

  logic [ST_W-1:0]   rd_data, wr_data;
  logic [SUM_W-1:0]  s1_new;
  logic [SQ_W-1:0]   s2_new;
  logic [15:0]       sq;
  logic              wr_en;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == F_IDLE);

  always_comb begin
    bs_e = (bs_r == '0) ? BS_W'(1) : (bs_r > BS_W'(MAX_BLOCK)) ? BS_W'(MAX_BLOCK) : bs_r;
    w_e  = (w_r == '0) ? DIM_W'(1) : (w_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_r;
    h_e  = (h_r == '0) ? DIM_W'(1) : (h_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_r;

    cc0  = in_sof ? '0 : cc_r;
    rc0  = in_sof ? '0 : rc_r;
    bci0 = in_sof ? '0 : bci_r;
    bri0 = in_sof ? '0 : bri_r;
    cib0 = in_sof ? '0 : cib_r;
    rib0 = in_sof ? '0 : rib_r;

    active = (rc0 < h_e);
    // A block column or row is complete inside the frame when its far edge fits.
    colp     = 19'({1'b0, bci0} + 13'd1) * 19'(bs_e);
    rowp     = 19'({1'b0, bri0} + 13'd1) * 19'(bs_e);
    in_blk   = (colp <= 19'(w_e)) && (rowp <= 19'(h_e));
    last_col = (colp + 19'(bs_e)) > 19'(w_e);
    last_row = (rowp + 19'(bs_e)) > 19'(h_e);
    first    = (cib0 == '0) && (rib0 == '0);
    emit     = ((cib0 + BS_W'(1)) >= bs_e) && ((rib0 + BS_W'(1)) >= bs_e);

    cc1  = cc0 + CNT_W'(1);
    rc1  = rc0;
    cib1 = cib0 + BS_W'(1);
    rib1 = rib0;
    bci1 = bci0;
    bri1 = bri0;
    if (cib1 >= bs_e) begin
      cib1 = '0;
      bci1 = bci0 + CNT_W'(1);
    end
    if (cc1 >= w_e) begin
      cc1  = '0;
      cib1 = '0;
      bci1 = '0;
      rc1  = rc0 + CNT_W'(1);
      rib1 = rib0 + BS_W'(1);
      if (rib1 >= bs_e) begin
        rib1 = '0;
        bri1 = bri0 + CNT_W'(1);
      end
    end
  end

  always_comb begin
    sq      = pix_r * pix_r;
    s1_new  = first_r ? SUM_W'(pix_r) : rd_data[ST_W-1:SQ_W] + SUM_W'(pix_r);
    s2_new  = first_r ? SQ_W'(sq) : rd_data[SQ_W-1:0] + SQ_W'(sq);
    wr_data = {s1_new, s2_new};
    wr_en   = (state_r == F_UPD) && !(emit_r && full);
    push    = wr_en && emit_r;
    push_item = '{s1: s1_new, s2: s2_new, n: n_r, block_row: orow_r,
                  block_col: ocol_r, frame_done: fdone_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept && active && in_blk) begin
          state_nxt = F_UPD;
        end
      end
      F_UPD: begin
        if (wr_en) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      bs_r    <= BS_W'(7);
      w_r     <= DIM_W'(640);
      h_r     <= DIM_W'(480);
      cc_r    <= '0;
      rc_r    <= '0;
      bci_r   <= '0;
      bri_r   <= '0;
      cib_r   <= '0;
      rib_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_BLOCK_SIZE:   bs_r <= cfg_data[BS_W-1:0];
          REG_IMAGE_WIDTH:  w_r  <= cfg_data;
          REG_IMAGE_HEIGHT: h_r  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        cc_r  <= active ? cc1  : cc0;
        rc_r  <= active ? rc1  : rc0;
        bci_r <= active ? bci1 : bci0;
        bri_r <= active ? bri1 : bri0;
        cib_r <= active ? cib1 : cib0;
        rib_r <= active ? rib1 : rib0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r   <= in_pixel;
      first_r <= first;
      emit_r  <= emit;
      addr_r  <= bci0[ADDR_W-1:0];
      n_r     <= N_W'(bs_e * bs_e);
      orow_r  <= bri0[IDX_W-1:0];
      ocol_r  <= bci0[IDX_W-1:0];
      fdone_r <= last_col && last_row;
    end
  end

  scb_ram #(.WIDTH(ST_W), .DEPTH(MAX_WIDTH)) u_sums (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_r),
    .wdata (wr_data),
    .re    (accept),
    .raddr (bci0[ADDR_W-1:0]),
    .rdata (rd_data)
  );

endmodule
`default_nettype wire

// ----- rtl/scb_back.sv -----
// ---------------------------------------------------------------------------
// Speckle contrast back end
// Works out floor(255*sqrt(n*S2-S1^2)/S1), capped at 255, one result bit per try-and-compare pass.
// ---------------------------------------------------------------------------
`default_nettype none
module scb_back
  import scb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              empty,
  input  scb_item_t              pop_item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [RES_W-1:0]       out_contrast,
  output logic [IDX_W-1:0]       out_row,
  output logic [IDX_W-1:0]       out_col,
  output logic                   out_frame_done
);

  typedef enum logic [7:0] {
    B_IDLE = 8'b00000001,
    B_PROD = 8'b00000010,
    B_DIFF = 8'b00000100,
    B_SC1  = 8'b00001000,
    B_SC2  = 8'b00010000,
    B_TRY  = 8'b00100000,
    B_CMP  = 8'b01000000,
    B_FIN  = 8'b10000000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  scb_item_t        it_r;
  logic [36:0]      a_r, b_r, d_r;
  logic [44:0]      x1_r;
  logic [52:0]      x_r;
  logic [25:0]      t_r;
  logic [51:0]      tsq;
  logic [RES_W-1:0] res_r, bit_r;
  logic             out_valid_r, load_out;

  assign pop       = (state_r == B_IDLE) && !empty;
  assign load_out  = (state_r == B_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign tsq       = t_r * t_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!empty) state_nxt = B_PROD;
      B_PROD: state_nxt = B_DIFF;
      B_DIFF: state_nxt = B_SC1;
      B_SC1:  state_nxt = B_SC2;
      B_SC2:  state_nxt = B_TRY;
      B_TRY:  state_nxt = B_CMP;
      B_CMP:  state_nxt = bit_r[0] ? B_FIN : B_TRY;
      B_FIN:  if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        it_r  <= pop_item;
        res_r <= '0;
        bit_r <= 8'h80;
      end
      B_PROD: begin
        a_r <= 37'(it_r.n) * 37'(it_r.s2);
        b_r <= 37'(it_r.s1 * it_r.s1);
      end
      B_DIFF: d_r <= (a_r > b_r) ? a_r - b_r : '0;
      B_SC1:  x1_r <= 45'(d_r) * 45'(SCALE);
      B_SC2:  x_r <= 53'(x1_r) * 53'(SCALE);
      // Largest result with (r*S1)^2 <= 255^2*d, found MSB first.
      B_TRY:  t_r <= 26'(res_r | bit_r) * 26'(it_r.s1);
      B_CMP: begin
        if ({1'b0, tsq} <= x_r) begin
          res_r <= res_r | bit_r;
        end
        bit_r <= bit_r >> 1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_contrast   <= (it_r.s1 == '0) ? '0 : res_r;
      out_row        <= it_r.block_row;
      out_col        <= it_r.block_col;
      out_frame_done <= it_r.frame_done;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/speckle_contrast_blocks.sv -----
// Input: a pixel is taken in F_IDLE; one that falls inside a full block then
// holds in_tready low in F_UPD for the read-modify-write of the block-column
// sum RAM, longer while the queue is full. Output: the back end takes one
// queued block at a time and finds its eight-bit result bit by bit with an
// iterative root; up to two finished blocks wait in the queue meanwhile.
// Reset: synchronous, active low; clears counters and queues, loads block size
// 7 and a 640x480 frame. The sum RAM is not cleared.
// ---------------------------------------------------------------------------
// Speckle contrast blocks
// Block-wise speckle contrast over a raster pixel stream.
// ---------------------------------------------------------------------------
`default_nettype none
module speckle_contrast_blocks
  import scb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] pixel
  input  wire logic             in_tuser,   // [0] start_of_frame
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [31:0]           out_tdata,  // [7:0] contrast, [18:8] block_row,
                                            // [29:19] block_col, [31:30] zero
  output logic                  out_tlast   // frame_done
);

  scb_item_t        push_item, pop_item;
  logic             push, pop, full, empty;
  logic [RES_W-1:0] contrast;
  logic [IDX_W-1:0] brow, bcol;

  assign cfg_ready = 1'b1;
  assign out_tdata = {2'b00, bcol, brow, contrast};

  scb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata),
    .in_sof    (in_tuser),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  scb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  scb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop_item       (pop_item),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_contrast   (contrast),
    .out_row        (brow),
    .out_col        (bcol),
    .out_frame_done (out_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/scb_checker.sv -----
// ---------------------------------------------------------------------------
// Speckle contrast blocks checker
// Port-level checks, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module scb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);

  // A result waiting for the sink keeps its value.
  `SCB_ASSERT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // Reset leaves no result pending and the input side open.
  `SCB_ASSERT_RST(a_rst_out, !rst_n, !out_tvalid)
  `SCB_ASSERT_RST(a_rst_in, !rst_n, in_tready)

endmodule

bind speckle_contrast_blocks scb_checker u_scb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
